[src/sequential_list_table_macros.svh]
// Assertion macros used by the list table RTL.
`ifndef SEQUENTIAL_LIST_TABLE_MACROS_SVH
`define SEQUENTIAL_LIST_TABLE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define SLT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/slt_pkg.sv]
// Types, codes and defaults for the sequential list table.
`timescale 1ns / 1ps
package slt_pkg;

  localparam int SLT_DEPTH  = 64;
  localparam int SLT_ELEM_W = 32;

  // Request modes
  localparam logic [1:0] MODE_FIND   = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_BAD_POS   = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] value;
    logic [6:0]  position;
  } slt_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] found_index;
    logic [6:0] count;
  } slt_out_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_SHIFT_UP,
    OP_SHIFT_DOWN
  } slt_op_t;

  // Broadcast command from the controller to every cell
  typedef struct packed {
    slt_op_t op;
    logic    probe_clr;
  } slt_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } slt_state_t;

endpackage

[src/slt_cell.sv]
// One list cell: holds an element and one stage of the search probe line.
`timescale 1ns / 1ps
module slt_cell
  import slt_pkg::*;
#(
  parameter int ELEMENT_WIDTH = SLT_ELEM_W,
  parameter int IDX_W         = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [IDX_W-1:0]         cell_idx,
  input  slt_cmd_t                 cmd,
  input  logic [IDX_W-1:0]         pos0,
  input  logic [ELEMENT_WIDTH-1:0] ins_value,
  input  logic [ELEMENT_WIDTH-1:0] left_data,
  input  logic [ELEMENT_WIDTH-1:0] right_data,
  input  logic                     probe_v_in,
  input  logic [ELEMENT_WIDTH-1:0] probe_val_in,
  output logic [ELEMENT_WIDTH-1:0] data,
  output logic                     probe_v,
  output logic [ELEMENT_WIDTH-1:0] probe_val,
  output logic                     hit
);

  logic [ELEMENT_WIDTH-1:0] data_r, data_nxt;
  logic                     probe_v_r, probe_v_nxt;
  logic [ELEMENT_WIDTH-1:0] probe_val_r;

  always_comb begin
    data_nxt = data_r;
    case (cmd.op)
      OP_SHIFT_UP: begin
        if (cell_idx > pos0) begin
          data_nxt = left_data;
        end else if (cell_idx == pos0) begin
          data_nxt = ins_value;
        end
      end
      OP_SHIFT_DOWN: begin
        if (cell_idx >= pos0) begin
          data_nxt = right_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  // Drop the probe everywhere when the controller ends a search
  assign probe_v_nxt = probe_v_in & ~cmd.probe_clr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_v_r <= 1'b0;
    end else begin
      probe_v_r <= probe_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r      <= data_nxt;
    probe_val_r <= probe_val_in;
  end

  assign data      = data_r;
  assign probe_v   = probe_v_r;
  assign probe_val = probe_val_r;
  assign hit       = probe_v_r && (data_r == probe_val_r);

endmodule

[src/sequential_list_table.sv]
// Top level of the sequential list table: controller and row of list cells.
`timescale 1ns / 1ps
//
//  channel  ports                          handshake
//  -------  -----------------------------  ------------------------------------
//  input    start, busy, in_item           beat taken when start && !busy
//  result   out_valid, out_item            one-cycle strobe, no back pressure
//
//  Insert and delete shift every cell at once on the accepting edge; the result
//  beat shows in the next cycle and a new request may be taken in that cycle.
//  Find sends a probe down the cell row, one cell per cycle, and busy stays high
//  until the probe reaches the matching index or, when nothing matches, the count.
//  The probe walk through the cell chain sets how long a find lasts.
//  Reset (rst_n low, synchronous) empties the list at once; element contents
//  are not cleared, since only entries below the count are ever looked at.
//  The receiver cannot stall; each result beat lasts exactly one cycle.
//
module sequential_list_table
  import slt_pkg::*;
#(
  parameter int DEPTH         = SLT_DEPTH,
  parameter int ELEMENT_WIDTH = SLT_ELEM_W
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  slt_in_t  in_item,
  output logic     out_valid,
  output slt_out_t out_item
);

`include "sequential_list_table_macros.svh"

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = ((CNT_W > 7) ? CNT_W : 7) + 1;

  slt_state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] step_r, step_nxt;
  logic             out_valid_r, out_valid_nxt;
  slt_out_t         out_item_r, out_item_nxt;

  slt_cmd_t                 cmd;
  logic                     launch;
  logic [ELEMENT_WIDTH-1:0] elem;
  logic [CMP_W-1:0]         pos_w, cnt_w;
  logic [IDX_W-1:0]         pos0;
  logic                     list_full, ins_ok, del_ok, hit_any;

  logic [ELEMENT_WIDTH-1:0] data_w      [DEPTH];
  logic [ELEMENT_WIDTH-1:0] probe_val_w [DEPTH];
  logic                     probe_v_w   [DEPTH];
  logic [DEPTH-1:0]         hit_w;

  // Element is the request value cut or zero-extended to the element width
  assign elem  = ELEMENT_WIDTH'(in_item.value);
  assign pos_w = CMP_W'(in_item.position);
  assign cnt_w = CMP_W'(count_r);
  assign pos0  = IDX_W'(pos_w - CMP_W'(1));

  assign list_full = (count_r == CNT_W'(DEPTH));
  assign ins_ok    = (pos_w != '0) && (pos_w <= cnt_w + CMP_W'(1));
  assign del_ok    = (pos_w != '0) && (pos_w <= cnt_w);

  // Only one probe is ever in flight, so any hit belongs to cell step_r
  assign hit_any = |hit_w;

  // ---- cell row -----------------------------------------------------------
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [ELEMENT_WIDTH-1:0] left_d, right_d, pval_in;
    logic                     pv_in;

    if (k == 0) begin : g_head
      assign left_d  = '0;
      assign pv_in   = launch;
      assign pval_in = elem;
    end else begin : g_body
      assign left_d  = data_w[k-1];
      assign pv_in   = probe_v_w[k-1];
      assign pval_in = probe_val_w[k-1];
    end

    if (k == DEPTH - 1) begin : g_tail
      assign right_d = '0;
    end else begin : g_inner
      assign right_d = data_w[k+1];
    end

    slt_cell #(
      .ELEMENT_WIDTH (ELEMENT_WIDTH),
      .IDX_W         (IDX_W)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .cell_idx     (IDX_W'(k)),
      .cmd          (cmd),
      .pos0         (pos0),
      .ins_value    (elem),
      .left_data    (left_d),
      .right_data   (right_d),
      .probe_v_in   (pv_in),
      .probe_val_in (pval_in),
      .data         (data_w[k]),
      .probe_v      (probe_v_w[k]),
      .probe_val    (probe_val_w[k]),
      .hit          (hit_w[k])
    );
  end

  // ---- controller ---------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    step_nxt      = step_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    cmd           = '{op: OP_HOLD, probe_clr: 1'b0};
    launch        = 1'b0;
    busy          = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          out_item_nxt.found_index = '0;
          out_item_nxt.status      = STAT_OK;
          unique case (in_item.mode)
            MODE_FIND: begin
              // Send the probe into cell 0, from where it walks down the cell row
              launch    = 1'b1;
              step_nxt  = '0;
              state_nxt = ST_SEARCH;
            end
            MODE_INSERT: begin
              out_valid_nxt = 1'b1;
              if (list_full) begin
                out_item_nxt.status = STAT_FULL;
              end else if (!ins_ok) begin
                out_item_nxt.status = STAT_BAD_POS;
              end else begin
                cmd.op    = OP_SHIFT_UP;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            MODE_DELETE: begin
              out_valid_nxt = 1'b1;
              if (!del_ok) begin
                out_item_nxt.status = STAT_BAD_POS;
              end else begin
                cmd.op    = OP_SHIFT_DOWN;
                count_nxt = count_r - CNT_W'(1);
              end
            end
            default: begin
              out_valid_nxt       = 1'b1;
              out_item_nxt.status = STAT_BAD_POS;
            end
          endcase
          out_item_nxt.count = 7'(count_nxt);
        end
      end
      ST_SEARCH: begin
        busy = 1'b1;
        if (step_r == count_r) begin
          // Probe walked past the last live entry: no match
          out_valid_nxt            = 1'b1;
          out_item_nxt.status      = STAT_NOT_FOUND;
          out_item_nxt.found_index = '0;
          out_item_nxt.count       = 7'(count_r);
          cmd.probe_clr            = 1'b1;
          state_nxt                = ST_IDLE;
        end else if (hit_any) begin
          out_valid_nxt            = 1'b1;
          out_item_nxt.status      = STAT_OK;
          out_item_nxt.found_index = 6'(step_r);
          out_item_nxt.count       = 7'(count_r);
          cmd.probe_clr            = 1'b1;
          state_nxt                = ST_IDLE;
        end else begin
          step_nxt = step_r + CNT_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // ---- checks -------------------------------------------------------------
  `SLT_ASSERT(a_count_bound, count_r <= CNT_W'(DEPTH), "element count above depth")
  `SLT_ASSERT(a_step_bound, (state_r == ST_SEARCH) |-> (step_r <= count_r),
              "probe step ran past the count")
  `SLT_ASSERT(a_no_strobe_in_search, (state_r == ST_SEARCH) |-> !out_valid_r,
              "result strobe while a find is still running")
  `SLT_ASSERT(a_edit_result_next, (start && !busy && (in_item.mode != MODE_FIND)) |=> out_valid,
              "insert or delete gave no result in the next cycle")
  `SLT_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == ST_IDLE && !out_valid_r),
                     "controller not idle after reset")

endmodule

[sim/sequential_list_table_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the sequential list table: directed and random requests.
module sequential_list_table_tb;
  import slt_pkg::*;

  // The fourth op code has no package name; the block must refuse it.
  localparam logic [1:0] MODE_NOP = 2'd3;

  localparam int CYCLE_LIMIT  = 1_000_000;
  // A find on a full list keeps the block busy while the probe walks the whole
  // list; leave room for that twice over before calling the run done.
  localparam int DRAIN_CYCLES = 2 * SLT_DEPTH + 8;
  localparam int RANDOM_BEATS = 1150;

  // Mirror of the list contents plus the queue of results still owed by
  // the block. Requests are applied in acceptance order, so the mirror
  // always shows the list as the block will hold it once caught up.
  class list_mirror;
    logic [SLT_ELEM_W-1:0] entry [SLT_DEPTH];
    int       count  = 0;
    int       errors = 0;
    slt_out_t owed [$];

    // Apply one accepted request and queue the result it must produce.
    function void note_request(slt_in_t req);
      slt_out_t want;
      int       pos;
      bit       hit;
      want = '0;
      pos  = req.position;
      hit  = 1'b0;
      case (req.mode)
        MODE_FIND: begin
          // Lowest matching index wins; a miss reports index zero.
          want.status = STAT_NOT_FOUND;
          for (int k = 0; k < count; k++) begin
            if (!hit && entry[k] == req.value) begin
              hit              = 1'b1;
              want.status      = STAT_OK;
              want.found_index = 6'(k);
            end
          end
        end
        MODE_INSERT: begin
          // Full is checked ahead of the position range.
          if (count >= SLT_DEPTH) begin
            want.status = STAT_FULL;
          end else if (pos < 1 || pos > count + 1) begin
            want.status = STAT_BAD_POS;
          end else begin
            for (int k = count; k > pos - 1; k--) entry[k] = entry[k - 1];
            entry[pos - 1] = req.value;
            count++;
          end
        end
        MODE_DELETE: begin
          if (pos < 1 || pos > count) begin
            want.status = STAT_BAD_POS;
          end else begin
            for (int k = pos; k < count; k++) entry[k - 1] = entry[k];
            count--;
          end
        end
        default: begin
          want.status = STAT_BAD_POS;
        end
      endcase
      want.count = 7'(count);
      owed.push_back(want);
    endfunction

    // Compare one result beat against the oldest owed result.
    function void check_result(slt_out_t got);
      slt_out_t want;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, got status %0d index %0d count %0d",
                 $time, got.status, got.found_index, got.count);
        return;
      end
      want = owed.pop_front();
      if (got.status !== want.status) begin
        errors++;
        $display("%0t status mismatch: expected %0d, got %0d",
                 $time, want.status, got.status);
      end
      if (got.found_index !== want.found_index) begin
        errors++;
        $display("%0t found_index mismatch: expected %0d, got %0d",
                 $time, want.found_index, got.found_index);
      end
      if (got.count !== want.count) begin
        errors++;
        $display("%0t count mismatch: expected %0d, got %0d",
                 $time, want.count, got.count);
      end
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  slt_in_t  in_item;
  logic     out_valid;
  slt_out_t out_item;

  list_mirror mirror = new();
  int         cycles = 0;

  sequential_list_table u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run (every beat a full-list find
  // behind the longest sender gap).
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result beats last one cycle and cannot be held off: take each on the
  // edge that ends it. Values read here are the ones from before the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) mirror.check_result(out_item);
  end

  // Present one request and hold it until the block takes it. Start stays
  // high afterwards so back-to-back beats need no extra edge.
  task automatic send_beat(input slt_in_t req);
    start   <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    mirror.note_request(req);
  endtask

  // Drop start for a random stretch; pct is the per-cycle idle chance.
  task automatic idle_gap(input int pct);
    if ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < pct);
    end
  endtask

  // Hold off the sender until every owed result has come back.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (mirror.owed.size() != 0);
  endtask

  // Mix of a small pool (duplicates, repeat hits), the extremes and noise.
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 32'($urandom_range(0, 7));
    if (r == 4) return 32'hFFFF_FFFF;
    if (r == 5) return 32'h0000_0000;
    return $urandom;
  endfunction

  // Build one random request that steers the fill level toward goal.
  function automatic slt_in_t make_beat(int goal);
    slt_in_t req;
    int      cnt;
    int      roll;
    bit      grow;
    cnt          = mirror.count;
    req.value    = pick_value();
    req.position = 7'($urandom_range(0, 127));
    roll         = $urandom_range(0, 99);
    if (roll < 6) begin
      // Pure noise: any op code, any position.
      req.mode = 2'($urandom_range(0, 3));
    end else if (roll < 10) begin
      // Positions just outside the legal window.
      req.mode = ($urandom_range(0, 1) != 0) ? MODE_INSERT : MODE_DELETE;
      case ($urandom_range(0, 1))
        0:       req.position = 7'd0;
        default: req.position = (req.mode == MODE_INSERT) ? 7'(cnt + 2) : 7'(cnt + 1);
      endcase
    end else if (roll < 34) begin
      // Finds mostly look up a value that is really in the list.
      req.mode = MODE_FIND;
      if (cnt > 0 && $urandom_range(0, 2) != 0) begin
        req.value = mirror.entry[$urandom_range(0, cnt - 1)];
      end
    end else begin
      grow = (cnt < goal) || (cnt == goal && $urandom_range(0, 1) != 0);
      if (grow) begin
        req.mode     = MODE_INSERT;
        req.position = 7'($urandom_range(1, cnt + 1));
      end else begin
        req.mode     = MODE_DELETE;
        req.position = (cnt > 0) ? 7'($urandom_range(1, cnt)) : 7'd1;
      end
    end
    return req;
  endfunction

  initial begin
    int goal;
    int pct;
    int r;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_item <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-list refusals, both ends of every window, extremes.
    send_beat(slt_in_t'{MODE_FIND,   32'h0000_0000, 7'd0});   // find on empty
    send_beat(slt_in_t'{MODE_DELETE, 32'h0000_0000, 7'd1});   // delete on empty
    send_beat(slt_in_t'{MODE_DELETE, 32'hFFFF_FFFF, 7'd0});
    send_beat(slt_in_t'{MODE_INSERT, 32'h1111_1111, 7'd0});   // position zero
    send_beat(slt_in_t'{MODE_INSERT, 32'h2222_2222, 7'd2});   // past count+1
    send_beat(slt_in_t'{MODE_INSERT, 32'hFFFF_FFFF, 7'd1});
    send_beat(slt_in_t'{MODE_INSERT, 32'h0000_0000, 7'd1});   // push at front
    send_beat(slt_in_t'{MODE_INSERT, 32'h5A5A_5A5A, 7'd3});   // append at tail
    send_beat(slt_in_t'{MODE_INSERT, 32'h0000_0000, 7'd2});   // duplicate value
    send_beat(slt_in_t'{MODE_FIND,   32'h0000_0000, 7'd127}); // lowest match
    send_beat(slt_in_t'{MODE_FIND,   32'h5A5A_5A5A, 7'd0});
    send_beat(slt_in_t'{MODE_FIND,   32'hFFFF_FFFF, 7'd0});
    send_beat(slt_in_t'{MODE_FIND,   32'h1234_5678, 7'd0});   // not present
    send_beat(slt_in_t'{MODE_NOP,    32'hFFFF_FFFF, 7'd127}); // unused op code
    send_beat(slt_in_t'{MODE_INSERT, 32'hA5A5_A5A5, 7'd127});
    send_beat(slt_in_t'{MODE_INSERT, 32'hA5A5_A5A5, 7'd6});
    send_beat(slt_in_t'{MODE_DELETE, 32'h0000_0000, 7'd5});   // past count
    send_beat(slt_in_t'{MODE_DELETE, 32'h0000_0000, 7'd127});
    send_beat(slt_in_t'{MODE_DELETE, 32'hFFFF_FFFF, 7'd4});   // drop tail
    send_beat(slt_in_t'{MODE_DELETE, 32'h0000_0000, 7'd1});   // drop head
    send_beat(slt_in_t'{MODE_FIND,   32'hFFFF_FFFF, 7'd0});
    send_beat(slt_in_t'{MODE_INSERT, 32'hA5A5_A5A5, 7'd3});
    // Let the pipe run dry once before the random part.
    wait_drained();

    // Random: fill toward a goal level, linger there, then pick a new goal.
    // The first goal is a full list so the full refusal shows up early.
    goal = SLT_DEPTH;
    for (int ph = 0; ph < 3; ph++) begin
      pct = (ph == 0) ? 38 : (ph == 1) ? 83 : 0;
      for (int n = 0; n < RANDOM_BEATS / 3; n++) begin
        if (mirror.count == goal && $urandom_range(0, 7) == 0) begin
          r    = $urandom_range(0, 3);
          goal = (r == 0) ? 0 : (r == 1) ? SLT_DEPTH : $urandom_range(0, SLT_DEPTH);
        end
        send_beat(make_beat(goal));
        idle_gap(pct);
      end
      wait_drained();
    end

    // Give a stray late result time to show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
